/* design/plist_pkg.sv */
`default_nettype none

package plist_pkg;

   // Default number of entries in the element store.
   localparam int unsigned DefaultDepth = 64;

   // Field widths of the command and result channels.
   localparam int unsigned FuncWidth     = 2;
   localparam int unsigned ValueWidth    = 32;
   localparam int unsigned PositionWidth = 6;
   localparam int unsigned StatusWidth   = 2;

   // Command codes.
   localparam logic [FuncWidth-1:0] FuncAppend = 2'd0;
   localparam logic [FuncWidth-1:0] FuncInsert = 2'd1;
   localparam logic [FuncWidth-1:0] FuncRemove = 2'd2;
   localparam logic [FuncWidth-1:0] FuncDump   = 2'd3;

   // Result status codes.
   localparam logic [StatusWidth-1:0] StatusOk    = 2'd0;
   localparam logic [StatusWidth-1:0] StatusRange = 2'd1;
   localparam logic [StatusWidth-1:0] StatusFull  = 2'd2;
   localparam logic [StatusWidth-1:0] StatusEmpty = 2'd3;

endpackage

`default_nettype wire

/* design/positional_list_engine.sv */
`default_nettype none

// Ordered list of signed 32-bit values held in a single-port-write memory.
// Commands arrive on the req_ ports and are taken when start is high and busy
// is low. Results leave on the rsp_ ports, each valid for exactly one cycle
// while rsp_strobe is high; the receiver must take them as they come.
// Append, every refused command and a dump of an empty list give one result
// in the cycle after the transaction is accepted, and busy stays low.
// Insert and remove move one element at a time through the memory's
// registered read port, reading in ST_SHIFT_RD and writing in ST_SHIFT_WR;
// busy is high until the moves are done and the result is then registered.
// A dump reads one element per cycle, each result following in the next
// cycle with the registered read data, the last one marked by rsp_is_last.
// The element store needs no clearing after reset; reset only empties the
// list, clears the result strobe and returns the sequencer to idle, so a
// command may start as soon as reset is released.
module positional_list_engine #(
   parameter int unsigned DEPTH = plist_pkg::DefaultDepth
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic [plist_pkg::FuncWidth-1:0]         req_func,
   input  wire logic signed [plist_pkg::ValueWidth-1:0] req_value,
   input  wire logic [plist_pkg::PositionWidth-1:0]     req_position,
   output logic                                         rsp_strobe,
   output logic [plist_pkg::StatusWidth-1:0]            rsp_status,
   output logic signed [plist_pkg::ValueWidth-1:0]      rsp_element,
   output logic                                         rsp_is_last
);
   import plist_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned PW = (CW > PositionWidth) ? CW + 1 : PositionWidth + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DUMP
   } state_type;

   state_type                     state_ff, state_in;
   logic [AW-1:0]                 ptr_ff, ptr_in;
   logic [AW-1:0]                 stop_ff, stop_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic                          insert_ff, insert_in;
   logic signed [ValueWidth-1:0]  value_ff, value_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic [StatusWidth-1:0]        rsp_status_ff, rsp_status_in;
   logic                          rsp_dump_ff, rsp_dump_in;
   logic                          rsp_last_ff, rsp_last_in;

   // Element store and its registered read data.
   logic signed [ValueWidth-1:0]  mem [DEPTH];
   logic signed [ValueWidth-1:0]  rd_data_ff;
   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic [AW-1:0]                 mem_raddr;
   logic signed [ValueWidth-1:0]  mem_wdata;

   // Comparison operands, wide enough for both the count and the position.
   logic [PW-1:0]                 pos_w;
   logic [PW-1:0]                 pos_next_w;
   logic [PW-1:0]                 count_w;
   logic                          list_full;
   logic [AW-1:0]                 src_ptr;
   logic [AW-1:0]                 last_ptr;

   assign pos_w      = PW'(req_position);
   assign pos_next_w = pos_w + PW'(1);
   assign count_w    = PW'(count_ff);
   assign list_full  = (count_ff == CW'(DEPTH));
   assign last_ptr   = AW'(count_ff - CW'(1));

   // Insert copies downwards from the entry below; remove copies from above.
   assign src_ptr = insert_ff ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));

   // Sequencer next-state logic and memory port control.
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      stop_in       = stop_ff;
      count_in      = count_ff;
      insert_in     = insert_ff;
      value_in      = value_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_dump_in   = 1'b0;
      rsp_last_in   = 1'b1;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = rd_data_ff;
      mem_raddr     = ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_func)
                  FuncAppend: begin
                     rsp_strobe_in = 1'b1;
                     if (list_full) begin
                        rsp_status_in = StatusFull;
                     end else begin
                        mem_we        = 1'b1;
                        mem_waddr     = AW'(count_ff);
                        mem_wdata     = req_value;
                        count_in      = count_ff + CW'(1);
                        rsp_status_in = StatusOk;
                     end
                  end
                  FuncInsert: begin
                     if (count_ff == '0 || pos_w >= count_w) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = StatusRange;
                     end else if (list_full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = StatusFull;
                     end else begin
                        ptr_in    = AW'(count_ff);
                        stop_in   = AW'(pos_next_w);
                        insert_in = 1'b1;
                        value_in  = req_value;
                        state_in  = ST_SHIFT_RD;
                     end
                  end
                  FuncRemove: begin
                     if (pos_next_w >= count_w) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = StatusRange;
                     end else begin
                        ptr_in    = AW'(pos_next_w);
                        stop_in   = last_ptr;
                        insert_in = 1'b0;
                        state_in  = ST_SHIFT_RD;
                     end
                  end
                  FuncDump: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = StatusEmpty;
                     end else begin
                        ptr_in   = '0;
                        state_in = ST_DUMP;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SHIFT_RD: begin
            if (ptr_ff == stop_ff) begin
               // All elements moved: place the new value or drop the tail.
               if (insert_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = value_ff;
                  count_in  = count_ff + CW'(1);
               end else begin
                  count_in  = count_ff - CW'(1);
               end
               rsp_strobe_in = 1'b1;
               rsp_status_in = StatusOk;
               state_in      = ST_IDLE;
            end else begin
               mem_raddr = src_ptr;
               state_in  = ST_SHIFT_WR;
            end
         end

         ST_SHIFT_WR: begin
            mem_we   = 1'b1;
            ptr_in   = src_ptr;
            state_in = ST_SHIFT_RD;
         end

         ST_DUMP: begin
            // One read per cycle; the result follows with the read data.
            rsp_strobe_in = 1'b1;
            rsp_dump_in   = 1'b1;
            rsp_status_in = StatusOk;
            rsp_last_in   = (ptr_ff == last_ptr);
            ptr_in        = ptr_ff + AW'(1);
            if (ptr_ff == last_ptr) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer state and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      ptr_ff        <= ptr_in;
      stop_ff       <= stop_in;
      insert_ff     <= insert_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dump_ff   <= rsp_dump_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Element store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // Outputs.
   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_dump_ff ? rd_data_ff : '0;
   assign rsp_is_last = rsp_last_ff;

endmodule

`default_nettype wire

/* tb/sv/plist_checker.sv */
`default_nettype none

// Watches the command and result channels of the list engine. It keeps its own
// copy of the list and queues the results that each accepted transaction
// should produce, then compares every strobed result with the oldest of them.
module plist_checker (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire logic                                    busy,
   input  wire logic [plist_pkg::FuncWidth-1:0]         req_func,
   input  wire logic signed [plist_pkg::ValueWidth-1:0] req_value,
   input  wire logic [plist_pkg::PositionWidth-1:0]     req_position,
   input  wire logic                                    rsp_strobe,
   input  wire logic [plist_pkg::StatusWidth-1:0]       rsp_status,
   input  wire logic signed [plist_pkg::ValueWidth-1:0] rsp_element,
   input  wire logic                                    rsp_is_last,
   output int                                           failures,
   output int                                           outstanding,
   output int                                           list_length
);
   timeunit 1ns;
   timeprecision 1ps;

   import plist_pkg::*;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [ValueWidth-1:0]  element;
      logic                   is_last;
   } list_result_type;

   // Shadow copy of the list and the results still owed by the block.
   logic [ValueWidth-1:0] shadow_list [DefaultDepth];
   int                    shadow_count;
   list_result_type       owed_results [$];
   int                    mismatch_tally;

   initial begin
      shadow_count   = 0;
      mismatch_tally = 0;
      failures       = 0;
      outstanding    = 0;
      list_length    = 0;
   end

   function automatic void owe_result(input logic [StatusWidth-1:0] status,
                                      input logic [ValueWidth-1:0] element,
                                      input logic is_last);
      list_result_type entry;
      entry.status  = status;
      entry.element = element;
      entry.is_last = is_last;
      owed_results.push_back(entry);
   endfunction

   always @(posedge clock) begin
      list_result_type        oldest;
      logic [StatusWidth-1:0] outcome;
      int                     slot;
      if (reset) begin
         shadow_count = 0;
         owed_results.delete();
      end else begin
         // Results are checked before the new transaction is predicted, since a
         // result seen at this edge always belongs to an earlier transaction.
         if (rsp_strobe) begin
            if (owed_results.size() == 0) begin
               $error("unexpected result: status %0d, element %0d, is_last %0d",
                      rsp_status, rsp_element, rsp_is_last);
               mismatch_tally++;
            end else begin
               oldest = owed_results.pop_front();
               if (rsp_status !== oldest.status) begin
                  $error("rsp_status mismatch: expected %0d, actual %0d",
                         oldest.status, rsp_status);
                  mismatch_tally++;
               end
               if (rsp_element !== oldest.element) begin
                  $error("rsp_element mismatch: expected %0d, actual %0d",
                         $signed(oldest.element), rsp_element);
                  mismatch_tally++;
               end
               if (rsp_is_last !== oldest.is_last) begin
                  $error("rsp_is_last mismatch: expected %0d, actual %0d",
                         oldest.is_last, rsp_is_last);
                  mismatch_tally++;
               end
            end
         end

         // Apply the accepted command to the shadow list.
         if (start && !busy) begin
            slot = int'(req_position);
            if (req_func == FuncDump) begin
               if (shadow_count == 0) begin
                  owe_result(StatusEmpty, '0, 1'b1);
               end else begin
                  for (int i = 0; i < shadow_count; i++)
                     owe_result(StatusOk, shadow_list[i], i == shadow_count - 1);
               end
            end else begin
               case (req_func)
                  FuncAppend: begin
                     if (shadow_count >= DefaultDepth) begin
                        outcome = StatusFull;
                     end else begin
                        shadow_list[shadow_count] = req_value;
                        shadow_count++;
                        outcome = StatusOk;
                     end
                  end
                  FuncInsert: begin
                     // The range check takes precedence over the full check.
                     if (shadow_count == 0 || slot > shadow_count - 1) begin
                        outcome = StatusRange;
                     end else if (shadow_count >= DefaultDepth) begin
                        outcome = StatusFull;
                     end else begin
                        for (int i = shadow_count; i > slot + 1; i--)
                           shadow_list[i] = shadow_list[i-1];
                        shadow_list[slot+1] = req_value;
                        shadow_count++;
                        outcome = StatusOk;
                     end
                  end
                  default: begin
                     // Removing after the last element names nothing.
                     if (shadow_count == 0 || slot >= shadow_count - 1) begin
                        outcome = StatusRange;
                     end else begin
                        for (int i = slot + 1; i + 1 < shadow_count; i++)
                           shadow_list[i] = shadow_list[i+1];
                        shadow_count--;
                        outcome = StatusOk;
                     end
                  end
               endcase
               owe_result(outcome, '0, 1'b1);
            end
         end
      end
      failures    <= mismatch_tally;
      outstanding <= owed_results.size();
      list_length <= shadow_count;
   end

endmodule

`default_nettype wire

/* tb/sv/tb_positional_list_engine.sv */
`default_nettype none

module tb_positional_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import plist_pkg::*;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [FuncWidth-1:0]         req_func;
   logic signed [ValueWidth-1:0] req_value;
   logic [PositionWidth-1:0]     req_position;
   logic                         rsp_strobe;
   logic [StatusWidth-1:0]       rsp_status;
   logic signed [ValueWidth-1:0] rsp_element;
   logic                         rsp_is_last;

   int failures;
   int outstanding;
   int list_length;
   int sender_idle_pct;

   positional_list_engine dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_element  (rsp_element),
      .rsp_is_last  (rsp_is_last)
   );

   plist_checker list_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_element  (rsp_element),
      .rsp_is_last  (rsp_is_last),
      .failures     (failures),
      .outstanding  (outstanding),
      .list_length  (list_length)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Guard against a hung block.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Present one command and hold it until the block takes the transaction.
   // Idle cycles carry random junk on the fields with start low.
   task automatic issue(input logic [FuncWidth-1:0] func,
                        input logic [ValueWidth-1:0] value,
                        input logic [PositionWidth-1:0] position);
      while ($urandom_range(99) < sender_idle_pct) begin
         start        <= 1'b0;
         req_func     <= FuncWidth'($urandom);
         req_value    <= $urandom;
         req_position <= PositionWidth'($urandom);
         @(posedge clock);
      end
      start        <= 1'b1;
      req_func     <= func;
      req_value    <= value;
      req_position <= position;
      do @(posedge clock); while (busy);
   endtask

   // A growing mix fills the store to its limit; a shrinking mix drains it.
   // Positions mostly fall inside the list so that shifts really happen.
   task automatic random_command(input bit growing);
      int                     pick;
      int                     length;
      logic [FuncWidth-1:0]     func;
      logic [PositionWidth-1:0] position;
      pick   = $urandom_range(99);
      length = list_length;
      if (growing)
         func = pick < 55 ? FuncAppend : pick < 90 ? FuncInsert :
                pick < 93 ? FuncRemove : FuncDump;
      else
         func = pick < 60 ? FuncRemove : pick < 70 ? FuncAppend :
                pick < 80 ? FuncInsert : FuncDump;
      position = PositionWidth'($urandom);
      if ($urandom_range(99) < 85) begin
         if (func == FuncRemove && length > 1)
            position = PositionWidth'($urandom_range(length - 2));
         else if (func != FuncRemove && length > 0)
            position = PositionWidth'($urandom_range(length - 1));
      end
      issue(func, $urandom, position);
   endtask

   initial begin
      start           = 1'b0;
      req_func        = FuncAppend;
      req_value       = '0;
      req_position    = '0;
      sender_idle_pct = 32;
      reset           = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, value extremes, both ends of the list,
      // out-of-range positions and removal after the last element.
      issue(FuncDump,   32'd0,          6'd0);
      issue(FuncInsert, 32'd7,          6'd0);
      issue(FuncRemove, 32'd0,          6'd0);
      issue(FuncAppend, 32'h7fff_ffff,  6'd63);
      issue(FuncAppend, 32'h8000_0000,  6'd0);
      issue(FuncInsert, 32'd0,          6'd0);
      issue(FuncInsert, 32'hffff_ffff,  6'd2);
      issue(FuncInsert, 32'd1,          6'd4);
      issue(FuncInsert, 32'd2,          6'd63);
      issue(FuncRemove, 32'd0,          6'd3);
      issue(FuncRemove, 32'd0,          6'd63);
      issue(FuncDump,   32'hffff_ffff,  6'd63);
      issue(FuncRemove, 32'd0,          6'd0);
      issue(FuncRemove, 32'd0,          6'd1);
      issue(FuncAppend, 32'h5555_5555,  6'd0);
      issue(FuncAppend, 32'haaaa_aaaa,  6'd0);
      issue(FuncDump,   32'd0,          6'd0);

      // Random: three idling regimes over a grow-then-drain sequence.
      for (int i = 0; i < 113; i++) begin
         sender_idle_pct = i < 38 ? 32 : i < 76 ? 81 : 0;
         random_command(i < 80);
      end
      start <= 1'b0;

      // Drain the remaining results, then allow for the slowest shift.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2 * DefaultDepth + 4) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

/* positional_list_engine.f */
design/plist_pkg.sv
design/positional_list_engine.sv
tb/sv/plist_checker.sv
tb/sv/tb_positional_list_engine.sv
